### sv/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants for the tail-drop FIFO link scheduler
// Field widths, register indexes, operation codes and the control bundle
// that drives the shared service-time unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

   localparam int TIME_W     = 48;
   localparam int ID_W       = 32;
   localparam int LEN_W      = 16;
   localparam int CAP_W      = 16;
   localparam int TPU_W      = 24;
   localparam int PROD_W     = LEN_W + TPU_W;
   localparam int ENTRY_W    = ID_W + LEN_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [CAP_W-1:0]  CAP_RESET = 16'hFFFF;
   localparam logic [TPU_W-1:0]  TPU_RESET = 24'd256;

   // register index as decoded from csr_paddr[2]
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_TPU      = 1'b1;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_FLUSH   = 1'b1;

   typedef struct packed {
      logic              mul_load;
      logic [LEN_W-1:0]  mul_len;
      logic [TIME_W-1:0] add_base;
   } svc_ctrl_type;

endpackage

`default_nettype wire

### sv/tdf_ram.sv
// ----------------------------------------------------------------------------
// tdf_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered on rd_en.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/tdf_svc_unit.sv
// ----------------------------------------------------------------------------
// tdf_svc_unit: shared service-time multiply and saturating time add
// Registers length * time_per_unit, then adds it to a time base with
// saturation at the largest time.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_svc_unit (
   input  wire logic                        clock,
   input  wire tdf_pkg::svc_ctrl_type       ctrl,
   input  wire logic [tdf_pkg::TPU_W-1:0]   time_per_unit,
   output logic      [tdf_pkg::TIME_W-1:0]  sum
);

   logic [tdf_pkg::PROD_W-1:0] prod_ff;
   logic [tdf_pkg::PROD_W-1:0] prod_in;
   logic [tdf_pkg::TIME_W:0]   wide_sum;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.mul_load) begin
         prod_in = tdf_pkg::PROD_W'(ctrl.mul_len) * tdf_pkg::PROD_W'(time_per_unit);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // product is below 2^40, so one carry bit flags overflow
   assign wide_sum = {1'b0, ctrl.add_base} + (tdf_pkg::TIME_W + 1)'(prod_ff);
   assign sum      = wide_sum[tdf_pkg::TIME_W] ? tdf_pkg::TIME_MAX
                                               : wide_sum[tdf_pkg::TIME_W-1:0];

endmodule

`default_nettype wire

### sv/tail_drop_fifo_link_scheduler.sv
// ----------------------------------------------------------------------------
// tail_drop_fifo_link_scheduler: output-port FIFO with tail drop and link timing
// Queues packets up to a length capacity and an entry limit, and reports
// each packet's departure time on the link as it leaves.
// ----------------------------------------------------------------------------
// An arrival item first releases, oldest first, every queued packet whose
// departure time is at or before the arrival time, then enqueues the packet
// if it fits (occupancy + length <= capacity and a free entry); otherwise it
// is dropped with no result. A packet longer than the capacity is ignored
// and leaves the state alone. A flush item releases the whole queue. Each
// released packet gives one result item; the final result of an input item
// has last_departure set. Times are 48-bit unsigned, 8 fraction bits, and
// saturate. Steps per item: an arrival that releases nothing passes accept,
// check and enqueue, plus a departure clock restart when the link is idle;
// an oversized arrival or a flush of an empty queue stops after check. Each
// released packet adds head data off the queue RAM, multiply of the next
// head's length by time_per_unit, saturating add and result load, except
// the one that empties the queue: on an arrival the clock restarts from the
// arrival instead of a next head being read, and on a flush only the result
// load follows, with no enqueue. These steps come from the single shared
// multiply/add unit and the registered queue RAM read; a stalled result
// side holds the result load. The block is ready only between items.
// Queue entries need no clearing after reset.
// Registers sit at byte address 0 (buffer_capacity) and 4 (time_per_unit).
// ----------------------------------------------------------------------------
`default_nettype none

module tail_drop_fifo_link_scheduler #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // arrival / flush items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_operation,
   input  wire logic [tdf_pkg::TIME_W-1:0]        req_arrival_time,
   input  wire logic [tdf_pkg::ID_W-1:0]          req_packet_id,
   input  wire logic [tdf_pkg::LEN_W-1:0]         req_packet_length,
   // departure items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [tdf_pkg::TIME_W-1:0]        rsp_depart_time,
   output logic      [tdf_pkg::ID_W-1:0]          rsp_depart_id,
   output logic      [tdf_pkg::LEN_W-1:0]         rsp_depart_length,
   output logic                                   rsp_last_departure,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [tdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [tdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;  // waiting for an item
   localparam logic [2:0] ST_CHECK   = 3'd1;  // decide drop / pop / restart
   localparam logic [2:0] ST_POP     = 3'd2;  // head data from RAM, unlink it
   localparam logic [2:0] ST_NXT_MUL = 3'd3;  // new head length * tpu
   localparam logic [2:0] ST_ADD_NXT = 3'd4;  // next_departure += service
   localparam logic [2:0] ST_ADD_ARR = 3'd5;  // next_departure = arrival + service
   localparam logic [2:0] ST_EMIT    = 3'd6;  // load result register
   localparam logic [2:0] ST_ENQ     = 3'd7;  // tail-drop enqueue

   logic [2:0] state_ff, state_in;

   // latched item
   logic                           op_ff, op_in;
   logic [tdf_pkg::TIME_W-1:0]     arr_ff, arr_in;
   logic [tdf_pkg::ID_W-1:0]       id_ff, id_in;
   logic [tdf_pkg::LEN_W-1:0]      len_ff, len_in;

   // queue bookkeeping
   logic [ADDR_W-1:0]              head_ff, head_in;
   logic [ADDR_W-1:0]              tail_ff, tail_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [tdf_pkg::CAP_W-1:0]      occ_ff, occ_in;
   logic [tdf_pkg::TIME_W-1:0]     nd_ff, nd_in;

   // popped packet waiting for its last flag
   logic [tdf_pkg::TIME_W-1:0]     hold_time_ff, hold_time_in;
   logic [tdf_pkg::ID_W-1:0]       hold_id_ff, hold_id_in;
   logic [tdf_pkg::LEN_W-1:0]      hold_len_ff, hold_len_in;
   logic                           pend_ff, pend_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tdf_pkg::TIME_W-1:0]     rsp_time_ff, rsp_time_in;
   logic [tdf_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [tdf_pkg::LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic                           rsp_last_ff, rsp_last_in;

   // configuration
   logic [tdf_pkg::CAP_W-1:0]      cap_ff, cap_in;
   logic [tdf_pkg::TPU_W-1:0]      tpu_ff, tpu_in;
   logic                           csr_we;

   // queue RAM and shared unit
   logic                           ram_we, ram_re;
   logic [ADDR_W-1:0]              ram_raddr;
   logic [tdf_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata;
   logic [tdf_pkg::ID_W-1:0]       ram_rd_id;
   logic [tdf_pkg::LEN_W-1:0]      ram_rd_len;
   tdf_pkg::svc_ctrl_type          svc_ctrl;
   logic [tdf_pkg::TIME_W-1:0]     svc_sum;

   logic                           more;
   logic                           out_free;
   logic                           fits;
   logic [ADDR_W-1:0]              head_next;
   logic [ADDR_W-1:0]              tail_next;

   assign ram_rd_id  = ram_rdata[tdf_pkg::ENTRY_W-1:tdf_pkg::LEN_W];
   assign ram_rd_len = ram_rdata[tdf_pkg::LEN_W-1:0];
   assign ram_wdata  = {id_ff, len_ff};

   assign head_next = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   // another departure follows the one being reported
   assign more     = (count_ff != '0) && ((op_ff == tdf_pkg::OP_FLUSH) || (nd_ff <= arr_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fits     = (({1'b0, occ_ff} + {1'b0, len_ff}) <= {1'b0, cap_ff})
                     && (count_ff < CNT_W'(QUEUE_DEPTH));

   //--------------------------------------------------------------------------
   // register port: 32-bit data, writes decode on address bit 2
   //--------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cap_in = cap_ff;
      tpu_in = tpu_ff;
      if (csr_we) begin
         case (csr_paddr[2])
            tdf_pkg::REG_CAPACITY: cap_in = csr_pwdata[tdf_pkg::CAP_W-1:0];
            tdf_pkg::REG_TPU:      tpu_in = csr_pwdata[tdf_pkg::TPU_W-1:0];
            default:               cap_in = cap_ff;
         endcase
      end
   end

   // misaligned reads return zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[2])
            tdf_pkg::REG_CAPACITY: csr_prdata = tdf_pkg::CSR_DATA_W'(cap_ff);
            tdf_pkg::REG_TPU:      csr_prdata = tdf_pkg::CSR_DATA_W'(tpu_ff);
            default:               csr_prdata = '0;
         endcase
      end
   end

   //--------------------------------------------------------------------------
   // sequencer
   //--------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      arr_in       = arr_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      occ_in       = occ_ff;
      nd_in        = nd_ff;
      hold_time_in = hold_time_ff;
      hold_id_in   = hold_id_ff;
      hold_len_in  = hold_len_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_time_in  = rsp_time_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = head_ff;
      svc_ctrl.mul_load = 1'b0;
      svc_ctrl.mul_len  = len_ff;
      svc_ctrl.add_base = nd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               arr_in   = req_arrival_time;
               id_in    = req_packet_id;
               len_in   = req_packet_length;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (op_ff == tdf_pkg::OP_FLUSH) begin
               if (count_ff != '0) begin
                  ram_re   = 1'b1;
                  state_in = ST_POP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (len_ff > cap_ff) begin
               // oversized: ignored outright
               state_in = ST_IDLE;
            end else if (nd_ff <= arr_ff) begin
               if (count_ff != '0) begin
                  ram_re   = 1'b1;
                  state_in = ST_POP;
               end else begin
                  // idle link restarts its clock at the arrival
                  svc_ctrl.mul_load = 1'b1;
                  pend_in  = 1'b0;
                  state_in = ST_ADD_ARR;
               end
            end else begin
               state_in = ST_ENQ;
            end
         end
         ST_POP: begin
            hold_time_in = nd_ff;
            hold_id_in   = ram_rd_id;
            hold_len_in  = ram_rd_len;
            pend_in      = 1'b1;
            count_in     = count_ff - 1'b1;
            head_in      = head_next;
            occ_in       = occ_ff - ram_rd_len;
            if (count_ff != CNT_W'(1)) begin
               ram_re    = 1'b1;
               ram_raddr = head_next;
               state_in  = ST_NXT_MUL;
            end else if (op_ff == tdf_pkg::OP_FLUSH) begin
               state_in = ST_EMIT;
            end else begin
               svc_ctrl.mul_load = 1'b1;
               state_in = ST_ADD_ARR;
            end
         end
         ST_NXT_MUL: begin
            svc_ctrl.mul_load = 1'b1;
            svc_ctrl.mul_len  = ram_rd_len;
            state_in = ST_ADD_NXT;
         end
         ST_ADD_NXT: begin
            nd_in    = svc_sum;
            state_in = ST_EMIT;
         end
         ST_ADD_ARR: begin
            svc_ctrl.add_base = arr_ff;
            nd_in    = svc_sum;
            state_in = pend_ff ? ST_EMIT : ST_ENQ;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = hold_time_ff;
               rsp_id_in    = hold_id_ff;
               rsp_len_in   = hold_len_ff;
               rsp_last_in  = !more;
               if (more) begin
                  ram_re   = 1'b1;
                  state_in = ST_POP;
               end else if (op_ff == tdf_pkg::OP_FLUSH) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ENQ;
               end
            end
         end
         ST_ENQ: begin
            if (fits) begin
               ram_we   = 1'b1;
               tail_in  = tail_next;
               count_in = count_ff + 1'b1;
               occ_in   = occ_ff + len_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         occ_ff       <= '0;
         nd_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= tdf_pkg::CAP_RESET;
         tpu_ff       <= tdf_pkg::TPU_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         occ_ff       <= occ_in;
         nd_ff        <= nd_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         tpu_ff       <= tpu_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      arr_ff       <= arr_in;
      id_ff        <= id_in;
      len_ff       <= len_in;
      hold_time_ff <= hold_time_in;
      hold_id_ff   <= hold_id_in;
      hold_len_ff  <= hold_len_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   tdf_ram #(
      .WIDTH (tdf_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tdf_svc_unit u_svc_unit (
      .clock         (clock),
      .ctrl          (svc_ctrl),
      .time_per_unit (tpu_ff),
      .sum           (svc_sum)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_depart_time    = rsp_time_ff;
   assign rsp_depart_id      = rsp_id_ff;
   assign rsp_depart_length  = rsp_len_ff;
   assign rsp_last_departure = rsp_last_ff;

   //--------------------------------------------------------------------------
   // checks
   //--------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_empty_no_occ: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (occ_ff == '0))
      else $error("empty queue with nonzero occupancy");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (count_ff != '0))
      else $error("pop from empty queue");

   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("queue RAM read and write in the same cycle");

endmodule

`default_nettype wire
